>>> hdl/bcf_pkg.sv
package bcf_pkg;

	// Frame arithmetic widths
	localparam int COORD_BITS   = 16;
	localparam int COUNT_BITS   = 20;
	localparam int SUM_BITS     = 36;
	localparam int MIN_POINTS   = 4000;
	localparam int DIV_STEPS    = SUM_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

	// Frame queue between front and back
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	// Register indexes on the configuration port
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Y       = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_Y       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_X       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_X       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_Z       = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_DISTANCE = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_FORWARD_GAIN    = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_TURN_GAIN       = 3'd7;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] box_min_y;
		logic signed [COORD_BITS-1:0] box_max_y;
		logic signed [COORD_BITS-1:0] box_min_x;
		logic signed [COORD_BITS-1:0] box_max_x;
		logic signed [COORD_BITS-1:0] box_max_z;
		logic signed [COORD_BITS-1:0] target_distance;
		logic        [COORD_BITS-1:0] forward_gain;
		logic        [COORD_BITS-1:0] turn_gain;
	} bcf_cfg_t;

	// Totals of one finished frame
	typedef struct packed {
		logic signed [SUM_BITS-1:0]   sum_x;
		logic signed [SUM_BITS-1:0]   sum_y;
		logic signed [COORD_BITS-1:0] min_z;
		logic        [COUNT_BITS-1:0] count;
		logic                         follow;
		logic                         person;
	} bcf_frame_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL,
		BK_SAT
	} bcf_back_state_t;

endpackage

>>> hdl/bcf_front.sv
module bcf_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bcf_pkg::bcf_cfg_t                     cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [bcf_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [bcf_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [bcf_pkg::COORD_BITS-1:0] point_z,
	input  logic                                  point_valid,
	input  logic                                  frame_end,
	input  logic                                  follow_enable,
	input  logic                                  person_seen,
	input  logic                                  q_full,
	output logic                                  q_push,
	output bcf_pkg::bcf_frame_t                   q_data
);

	logic signed [bcf_pkg::SUM_BITS-1:0]   sum_x_q, sum_y_q, sum_x_nx, sum_y_nx;
	logic signed [bcf_pkg::COORD_BITS-1:0] min_z_q, min_z_nx;
	logic        [bcf_pkg::COUNT_BITS-1:0] count_q, count_nx;
	logic signed [bcf_pkg::COORD_BITS:0]   neg_y;
	logic                                  hit, accept;

	// Stall only when the frame queue has no room
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Box test on the point itself, with -y taken at full precision
	always_comb begin
		neg_y = -{point_y[bcf_pkg::COORD_BITS-1], point_y};
		hit = point_valid
			&& (neg_y > $signed({cfg.box_min_y[bcf_pkg::COORD_BITS-1], cfg.box_min_y}))
			&& (neg_y < $signed({cfg.box_max_y[bcf_pkg::COORD_BITS-1], cfg.box_max_y}))
			&& (point_x > cfg.box_min_x) && (point_x < cfg.box_max_x)
			&& (point_z < cfg.box_max_z)
			&& (count_q != '1);
	end

	// Running totals including this point
	always_comb begin
		sum_x_nx = sum_x_q;
		sum_y_nx = sum_y_q;
		min_z_nx = min_z_q;
		count_nx = count_q;
		if (hit) begin
			sum_x_nx = sum_x_q + bcf_pkg::SUM_BITS'(point_x);
			sum_y_nx = sum_y_q + bcf_pkg::SUM_BITS'(point_y);
			if (point_z < min_z_q) begin
				min_z_nx = point_z;
			end
			count_nx = count_q + 1'b1;
		end
	end

	// Hand the frame totals to the back on the last beat
	assign q_push        = accept && frame_end;
	assign q_data.sum_x  = sum_x_nx;
	assign q_data.sum_y  = sum_y_nx;
	assign q_data.min_z  = min_z_nx;
	assign q_data.count  = count_nx;
	assign q_data.follow = follow_enable;
	assign q_data.person = person_seen;

	// Accumulate, clear after each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			min_z_q <= {1'b0, {(bcf_pkg::COORD_BITS-1){1'b1}}};
			count_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				min_z_q <= {1'b0, {(bcf_pkg::COORD_BITS-1){1'b1}}};
				count_q <= '0;
			end else begin
				sum_x_q <= sum_x_nx;
				sum_y_q <= sum_y_nx;
				min_z_q <= min_z_nx;
				count_q <= count_nx;
			end
		end
	end

endmodule

>>> hdl/bcf_queue.sv
module bcf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bcf_pkg::bcf_frame_t push_data,
	output logic                full,
	input  logic                pop,
	output bcf_pkg::bcf_frame_t pop_data,
	output logic                empty
);

	bcf_pkg::bcf_frame_t                 mem_q [bcf_pkg::QUEUE_DEPTH];
	logic [bcf_pkg::QPTR_BITS-1:0]       wr_ptr_q, rd_ptr_q;
	logic [bcf_pkg::QCNT_BITS-1:0]       cnt_q;
	logic                                do_push, do_pop;

	assign full     = (cnt_q == bcf_pkg::QCNT_BITS'(bcf_pkg::QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/bcf_back.sv
module bcf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bcf_pkg::bcf_cfg_t   cfg,
	input  logic                q_empty,
	input  bcf_pkg::bcf_frame_t q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                target_found,
	output logic                drive_issued,
	output logic signed [15:0]  linear_speed,
	output logic signed [15:0]  angular_speed,
	output logic signed [15:0]  centroid_x,
	output logic signed [15:0]  centroid_y,
	output logic signed [15:0]  nearest_z,
	output logic [bcf_pkg::COUNT_BITS-1:0] point_count
);

	localparam int SB = bcf_pkg::SUM_BITS;
	localparam int CB = bcf_pkg::COUNT_BITS;

	bcf_pkg::bcf_back_state_t           state_q, state_nx;
	bcf_pkg::bcf_frame_t                frame_q;
	logic [bcf_pkg::DIV_CNT_BITS-1:0]   step_q;
	logic [SB-1:0]                      quo_x_q, quo_y_q;
	logic [CB-1:0]                      rem_x_q, rem_y_q;
	logic                               neg_x_q, neg_y_q;
	logic [CB:0]                        shl_x, shl_y, dif_x, dif_y;
	logic                               ge_x, ge_y;
	logic [SB-1:0]                      cx_full, cy_full;
	logic signed [16:0]                 cx17, lin_diff, fg_s, tg_s;
	logic signed [17:0]                 neg_cx;
	logic signed [34:0]                 lin_prod, ang_prod;
	logic signed [34:0]                 lin_prod_s2, ang_prod_s2;
	logic signed [15:0]                 cx_s2, cy_s2, nz_s2;
	logic                               found_s2, drive_s2;
	logic                               found;
	logic                               load_out, start, div_done;

	function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
		logic signed [26:0] sh;
		sh = v[34:8];
		if (sh > 27'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (sh < -27'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = sh[15:0];
		end
	endfunction

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcf_pkg::BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and control
	always_comb begin
		state_nx = state_q;
		q_pop    = 1'b0;
		start    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			bcf_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop    = 1'b1;
					start    = 1'b1;
					state_nx = bcf_pkg::BK_DIV;
				end
			end
			bcf_pkg::BK_DIV: begin
				if (div_done) begin
					state_nx = bcf_pkg::BK_MUL;
				end
			end
			bcf_pkg::BK_MUL: begin
				state_nx = bcf_pkg::BK_SAT;
			end
			bcf_pkg::BK_SAT: begin
				if (!out_valid || out_ready) begin
					load_out = 1'b1;
					state_nx = bcf_pkg::BK_IDLE;
				end
			end
			default: begin
				state_nx = bcf_pkg::BK_IDLE;
			end
		endcase
	end

	assign div_done = (step_q == bcf_pkg::DIV_CNT_BITS'(bcf_pkg::DIV_STEPS - 1));

	// One restoring step per cycle for both sums
	always_comb begin
		shl_x = {rem_x_q, quo_x_q[SB-1]};
		shl_y = {rem_y_q, quo_y_q[SB-1]};
		dif_x = shl_x - {1'b0, frame_q.count};
		dif_y = shl_y - {1'b0, frame_q.count};
		ge_x  = !dif_x[CB];
		ge_y  = !dif_y[CB];
	end

	// Load magnitudes, then iterate
	always_ff @(posedge clk) begin
		if (start) begin
			frame_q <= q_data;
			neg_x_q <= q_data.sum_x[SB-1];
			neg_y_q <= q_data.sum_y[SB-1];
			quo_x_q <= q_data.sum_x[SB-1] ? SB'(-q_data.sum_x) : q_data.sum_x;
			quo_y_q <= q_data.sum_y[SB-1] ? SB'(-q_data.sum_y) : q_data.sum_y;
			rem_x_q <= '0;
			rem_y_q <= '0;
			step_q  <= '0;
		end else if (state_q == bcf_pkg::BK_DIV) begin
			quo_x_q <= {quo_x_q[SB-2:0], ge_x};
			quo_y_q <= {quo_y_q[SB-2:0], ge_y};
			rem_x_q <= ge_x ? dif_x[CB-1:0] : shl_x[CB-1:0];
			rem_y_q <= ge_y ? dif_y[CB-1:0] : shl_y[CB-1:0];
			step_q  <= step_q + 1'b1;
		end
	end

	// Signed centroid and gain products
	always_comb begin
		found    = (32'(frame_q.count) > 32'(bcf_pkg::MIN_POINTS)) && (frame_q.count != '0);
		cx_full  = neg_x_q ? SB'(-quo_x_q) : quo_x_q;
		cy_full  = neg_y_q ? SB'(-quo_y_q) : quo_y_q;
		cx17     = cx_full[16:0];
		neg_cx   = -{cx17[16], cx17};
		lin_diff = {frame_q.min_z[15], frame_q.min_z}
			- {cfg.target_distance[15], cfg.target_distance};
		fg_s     = {1'b0, cfg.forward_gain};
		tg_s     = {1'b0, cfg.turn_gain};
		lin_prod = 35'(lin_diff) * 35'(fg_s);
		ang_prod = 35'(neg_cx) * 35'(tg_s);
	end

	// Register products
	always_ff @(posedge clk) begin
		if (state_q == bcf_pkg::BK_MUL) begin
			lin_prod_s2 <= lin_prod;
			ang_prod_s2 <= ang_prod;
			cx_s2       <= found ? cx_full[15:0] : '0;
			cy_s2       <= found ? cy_full[15:0] : '0;
			nz_s2       <= found ? frame_q.min_z : '0;
			found_s2    <= found;
			drive_s2    <= found && frame_q.follow && frame_q.person;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			target_found  <= found_s2;
			drive_issued  <= frame_q.follow;
			linear_speed  <= drive_s2 ? sat16(lin_prod_s2) : '0;
			angular_speed <= drive_s2 ? sat16(ang_prod_s2) : '0;
			centroid_x    <= cx_s2;
			centroid_y    <= cy_s2;
			nearest_z     <= nz_s2;
			point_count   <= frame_q.count;
		end
	end

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcf_pkg::BK_DIV |-> step_q < bcf_pkg::DIV_CNT_BITS'(bcf_pkg::DIV_STEPS))
		else $error("divider step out of range");

	a_no_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !target_found) |-> (linear_speed == '0 && angular_speed == '0
			&& centroid_x == '0 && centroid_y == '0 && nearest_z == '0))
		else $error("result fields set without a target");

	a_sat_order: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == bcf_pkg::BK_SAT) |-> $past(state_q) == bcf_pkg::BK_MUL)
		else $error("saturation stage entered without products");

	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == bcf_pkg::BK_DIV && step_q == '0)
		else $error("frame popped without starting the divider");
`endif

endmodule

>>> hdl/box_centroid_follow_controller_top.sv
// Box centroid follower.
// Points enter on the s_axis channel, one beat per point; tlast marks the last
// point of a frame. Points inside the configured box are summed, the nearest
// depth and a count are kept. Each frame gives one result beat on m_axis with
// the centroid, nearest depth, count and the forward and turn commands.
// Throughput: one point per cycle. s_axis_tready drops only while the
// two-entry frame queue is full.
// When the back end is idle, the tlast beat reaches m_axis_tvalid through the
// queue, a pop into the back end, a restoring shift-subtract divider for each
// sum (one quotient bit per cycle for both sums), a register for the gain
// products, and a state that saturates and loads the result register.
// The back end takes one frame at a time, so a stream of short frames fills the
// queue and stalls the input.
// Registers are written on the cfg channel (always ready); keep writes to idle, the block does not enforce it.
// Reset clears the frame totals, empties the queue, drops m_axis_tvalid and
// loads the default box and gains.
// When m_axis_tready is low the result holds; the next frame waits in the back
// end and in the queue, and points keep flowing until the queue fills.
module box_centroid_follow_controller_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// point_x[15:0], point_y[31:16], point_z[47:32],
	// follow_enable[48], person_seen[49], zero[55:50]
	input  logic [55:0]                        s_axis_tdata,
	// point_valid[0]
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// target_found[0], drive_issued[1], linear_speed[17:2], angular_speed[33:18],
	// centroid_x[49:34], centroid_y[65:50], nearest_z[81:66],
	// point_count[101:82], zero[103:102]
	output logic [103:0]                       m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bcf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [15:0]                        cfg_data
);

	bcf_pkg::bcf_cfg_t   cfg_q;
	bcf_pkg::bcf_frame_t push_data, pop_data;
	logic                q_push, q_pop, q_full, q_empty;
	logic                target_found, drive_issued;
	logic signed [15:0]  linear_speed, angular_speed, centroid_x, centroid_y, nearest_z;
	logic [bcf_pkg::COUNT_BITS-1:0] point_count;

	// Register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_min_y       <= 16'sd100;
			cfg_q.box_max_y       <= 16'sd500;
			cfg_q.box_min_x       <= -16'sd200;
			cfg_q.box_max_x       <= 16'sd200;
			cfg_q.box_max_z       <= 16'sd800;
			cfg_q.target_distance <= 16'sd600;
			cfg_q.forward_gain    <= 16'd256;
			cfg_q.turn_gain       <= 16'd1280;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bcf_pkg::REG_BOX_MIN_Y:       cfg_q.box_min_y       <= cfg_data;
				bcf_pkg::REG_BOX_MAX_Y:       cfg_q.box_max_y       <= cfg_data;
				bcf_pkg::REG_BOX_MIN_X:       cfg_q.box_min_x       <= cfg_data;
				bcf_pkg::REG_BOX_MAX_X:       cfg_q.box_max_x       <= cfg_data;
				bcf_pkg::REG_BOX_MAX_Z:       cfg_q.box_max_z       <= cfg_data;
				bcf_pkg::REG_TARGET_DISTANCE: cfg_q.target_distance <= cfg_data;
				bcf_pkg::REG_FORWARD_GAIN:    cfg_q.forward_gain    <= cfg_data;
				bcf_pkg::REG_TURN_GAIN:       cfg_q.turn_gain       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bcf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.point_x       (s_axis_tdata[15:0]),
		.point_y       (s_axis_tdata[31:16]),
		.point_z       (s_axis_tdata[47:32]),
		.point_valid   (s_axis_tuser),
		.frame_end     (s_axis_tlast),
		.follow_enable (s_axis_tdata[48]),
		.person_seen   (s_axis_tdata[49]),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (push_data)
	);

	bcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	bcf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_data        (pop_data),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.target_found  (target_found),
		.drive_issued  (drive_issued),
		.linear_speed  (linear_speed),
		.angular_speed (angular_speed),
		.centroid_x    (centroid_x),
		.centroid_y    (centroid_y),
		.nearest_z     (nearest_z),
		.point_count   (point_count)
	);

	// Pack the result beat
	assign m_axis_tdata = {2'b00, point_count, nearest_z, centroid_y, centroid_x,
		angular_speed, linear_speed, drive_issued, target_found};

endmodule

>>> sim/tb_box_centroid_follow_controller_top.sv
module tb_box_centroid_follow_controller_top;

	localparam int COUNT_FULL    = (1 << bcf_pkg::COUNT_BITS) - 1;
	localparam int SETTLE_CYCLES = 60;
	localparam int RX_HOLD_CYCLES = 3000;

	// One point beat as the sender sees it
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               valid;
		logic               last;
		logic               follow;
		logic               person;
	} point_t;

	// One frame result beat
	typedef struct {
		logic                           target_found;
		logic                           drive_issued;
		logic signed [15:0]             linear_speed;
		logic signed [15:0]             angular_speed;
		logic signed [15:0]             centroid_x;
		logic signed [15:0]             centroid_y;
		logic signed [15:0]             nearest_z;
		logic [bcf_pkg::COUNT_BITS-1:0] point_count;
	} drive_result_t;

	class follow_scoreboard;
		int lo_y, hi_y, lo_x, hi_x, top_z, goal_z, fwd_gain, turn_gain;
		longint sum_x, sum_y;
		int min_depth;
		int accepted;
		drive_result_t frame_results_due[$];
		int fails, points, frames, targets, results_checked;

		function new();
			lo_y = 100;
			hi_y = 500;
			lo_x = -200;
			hi_x = 200;
			top_z = 800;
			goal_z = 600;
			fwd_gain = 256;
			turn_gain = 1280;
			clear_frame();
		endfunction

		function void clear_frame();
			sum_x = 0;
			sum_y = 0;
			min_depth = 32767;
			accepted = 0;
		endfunction

		function void load_reg(logic [bcf_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] data);
			case (idx)
				bcf_pkg::REG_BOX_MIN_Y:       lo_y = int'($signed(data));
				bcf_pkg::REG_BOX_MAX_Y:       hi_y = int'($signed(data));
				bcf_pkg::REG_BOX_MIN_X:       lo_x = int'($signed(data));
				bcf_pkg::REG_BOX_MAX_X:       hi_x = int'($signed(data));
				bcf_pkg::REG_BOX_MAX_Z:       top_z = int'($signed(data));
				bcf_pkg::REG_TARGET_DISTANCE: goal_z = int'($signed(data));
				bcf_pkg::REG_FORWARD_GAIN:    fwd_gain = int'(data);
				bcf_pkg::REG_TURN_GAIN:       turn_gain = int'(data);
				default: ;
			endcase
		endfunction

		function longint clamp16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		// Accumulate one accepted point beat; on the frame end queue its result
		function void fold_point(point_t p);
			int px, py, pz, ny;
			longint cx, cy, nz, lin, ang;
			drive_result_t r;
			px = int'(p.x);
			py = int'(p.y);
			pz = int'(p.z);
			ny = -py;
			points++;
			if (p.valid && ny > lo_y && ny < hi_y && px > lo_x && px < hi_x &&
					pz < top_z && accepted < COUNT_FULL) begin
				sum_x += px;
				sum_y += py;
				if (pz < min_depth)
					min_depth = pz;
				accepted++;
			end
			if (!p.last)
				return;
			cx = 0;
			cy = 0;
			nz = 0;
			lin = 0;
			ang = 0;
			r.target_found = accepted > bcf_pkg::MIN_POINTS;
			if (r.target_found) begin
				cx = sum_x / accepted;
				cy = sum_y / accepted;
				nz = min_depth;
				if (p.follow && p.person) begin
					lin = clamp16(((nz - goal_z) * fwd_gain) >>> 8);
					ang = clamp16((-cx * turn_gain) >>> 8);
				end
				targets++;
			end
			r.drive_issued = p.follow;
			r.linear_speed = 16'(lin);
			r.angular_speed = 16'(ang);
			r.centroid_x = 16'(cx);
			r.centroid_y = 16'(cy);
			r.nearest_z = 16'(nz);
			r.point_count = bcf_pkg::COUNT_BITS'(accepted);
			frame_results_due.push_back(r);
			frames++;
			clear_frame();
		endfunction

		function void check_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				fails++;
			end
		endfunction

		// Compare a result beat with the oldest frame still due
		function void check_frame_result(logic [103:0] beat);
			drive_result_t want;
			if (frame_results_due.size() == 0) begin
				$error("result beat with no frame pending: %h", beat);
				fails++;
				return;
			end
			want = frame_results_due.pop_front();
			results_checked++;
			check_field("target_found", longint'(want.target_found), longint'(beat[0]));
			check_field("drive_issued", longint'(want.drive_issued), longint'(beat[1]));
			check_field("linear_speed", longint'(want.linear_speed),
				longint'($signed(beat[17:2])));
			check_field("angular_speed", longint'(want.angular_speed),
				longint'($signed(beat[33:18])));
			check_field("centroid_x", longint'(want.centroid_x),
				longint'($signed(beat[49:34])));
			check_field("centroid_y", longint'(want.centroid_y),
				longint'($signed(beat[65:50])));
			check_field("nearest_z", longint'(want.nearest_z),
				longint'($signed(beat[81:66])));
			check_field("point_count", longint'(want.point_count),
				longint'(beat[101:82]));
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [55:0]                      s_axis_tdata = '0;
	logic                             s_axis_tuser = 1'b0;
	logic                             s_axis_tlast = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [103:0]                     m_axis_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [bcf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [15:0]                      cfg_data = '0;

	follow_scoreboard follow_check = new();
	bcf_pkg::bcf_cfg_t box;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int z_span = 100;
	bit rx_hold_req = 1'b0;
	int rx_hold_left = 0;

	box_centroid_follow_controller_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check every result beat taken by the receiver
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			follow_check.check_frame_result(m_axis_tdata);
	end

	// Drive the result ready: a long hold when requested, else random stalls
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left = RX_HOLD_CYCLES;
			rx_hold_req = 1'b0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic bcf_pkg::bcf_cfg_t default_config();
		bcf_pkg::bcf_cfg_t c;
		c.box_min_y = 16'sd100;
		c.box_max_y = 16'sd500;
		c.box_min_x = -16'sd200;
		c.box_max_x = 16'sd200;
		c.box_max_z = 16'sd800;
		c.target_distance = 16'sd600;
		c.forward_gain = 16'd256;
		c.turn_gain = 16'd1280;
		return c;
	endfunction

	function automatic bcf_pkg::bcf_cfg_t full_box_config();
		bcf_pkg::bcf_cfg_t c;
		c.box_min_y = 16'sh8000;
		c.box_max_y = 16'sh7FFF;
		c.box_min_x = 16'sh8000;
		c.box_max_x = 16'sh7FFF;
		c.box_max_z = 16'sh7FFF;
		c.target_distance = 16'sh8000;
		c.forward_gain = 16'hFFFF;
		c.turn_gain = 16'hFFFF;
		return c;
	endfunction

	function automatic int pick_in(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic bcf_pkg::bcf_cfg_t random_config();
		bcf_pkg::bcf_cfg_t c;
		int lo;
		lo = pick_in(-3000, 1000);
		c.box_min_x = 16'(lo);
		c.box_max_x = 16'(lo + pick_in(2, 4000));
		lo = pick_in(-1000, 1000);
		c.box_min_y = 16'(lo);
		c.box_max_y = 16'(lo + pick_in(2, 3000));
		c.box_max_z = 16'(pick_in(-500, 5000));
		c.target_distance = 16'(pick_in(-2000, 6000));
		c.forward_gain = 16'($urandom_range(65535));
		c.turn_gain = 16'($urandom_range(65535));
		return c;
	endfunction

	function automatic bit box_open();
		int lo_y, hi_y, lo_x, hi_x, top_z;
		lo_y = int'(box.box_min_y);
		hi_y = int'(box.box_max_y);
		lo_x = int'(box.box_min_x);
		hi_x = int'(box.box_max_x);
		top_z = int'(box.box_max_z);
		return (hi_y - lo_y >= 2) && (hi_x - lo_x >= 2) && (top_z > -32768);
	endfunction

	// Values on and next to a box edge, at the ends of the field range, or anywhere in it
	function automatic int pick_edge(int lo, int hi);
		case ($urandom_range(6))
			0: return lo;
			1: return lo + 1;
			2: return hi - 1;
			3: return hi;
			4: return -32768;
			5: return 32767;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	function automatic point_t mk_point(int x, int y, int z, bit valid, bit last,
			bit follow, bit person);
		point_t p;
		p.x = 16'(x);
		p.y = 16'(y);
		p.z = 16'(z);
		p.valid = valid;
		p.last = last;
		p.follow = follow;
		p.person = person;
		return p;
	endfunction

	// A valid point strictly inside the current box
	function automatic point_t inside_point();
		point_t p;
		int z;
		p.x = 16'(pick_in(int'(box.box_min_x) + 1, int'(box.box_max_x) - 1));
		p.y = 16'(-pick_in(int'(box.box_min_y) + 1, int'(box.box_max_y) - 1));
		z = int'(box.box_max_z) - 1 - int'($urandom_range(z_span));
		if (z < -32768)
			z = -32768;
		p.z = 16'(z);
		p.valid = 1'b1;
		p.last = 1'b0;
		p.follow = 1'($urandom_range(1));
		p.person = 1'($urandom_range(1));
		return p;
	endfunction

	function automatic point_t random_point();
		point_t p;
		int roll;
		roll = int'($urandom_range(99));
		if (roll < 70 && box_open()) begin
			p = inside_point();
		end else if (roll < 85) begin
			p.x = 16'(pick_edge(int'(box.box_min_x), int'(box.box_max_x)));
			p.y = 16'(-pick_edge(int'(box.box_min_y), int'(box.box_max_y)));
			p.z = 16'(pick_edge(int'(box.box_max_z) - 1, int'(box.box_max_z)));
		end else begin
			p.x = 16'($urandom);
			p.y = 16'($urandom);
			p.z = 16'($urandom);
		end
		p.valid = ($urandom_range(9) != 0);
		p.last = 1'b0;
		p.follow = 1'($urandom_range(1));
		p.person = 1'($urandom_range(1));
		return p;
	endfunction

	// Offer one point beat, with random gaps, and hold it until taken
	task automatic send_point(point_t p);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'd0, p.person, p.follow, p.z, p.y, p.x};
		s_axis_tuser = p.valid;
		s_axis_tlast = p.last;
		do @(posedge clk); while (!s_axis_tready);
		follow_check.fold_point(p);
		@(negedge clk);
	endtask

	task automatic send_frame(int n_points);
		point_t p;
		z_span = $urandom_range(1) ? int'($urandom_range(40)) : int'($urandom_range(40000));
		for (int i = 0; i < n_points; i++) begin
			p = random_point();
			p.last = (i == n_points - 1);
			send_point(p);
		end
	endtask

	task automatic run_frames(int budget, int max_len);
		int sent;
		int n;
		sent = 0;
		while (sent < budget) begin
			n = pick_in(1, ($urandom_range(4) == 0) ? max_len : (max_len + 4) / 5);
			send_frame(n);
			sent += n;
		end
	endtask

	// Drop the point beat and wait for every pending result
	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (follow_check.frame_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [bcf_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		follow_check.load_reg(idx, value);
		@(negedge clk);
	endtask

	// Load all registers while the block is idle
	task automatic apply_config(bcf_pkg::bcf_cfg_t c);
		wait_drained();
		write_reg(bcf_pkg::REG_BOX_MIN_Y, c.box_min_y);
		write_reg(bcf_pkg::REG_BOX_MAX_Y, c.box_max_y);
		write_reg(bcf_pkg::REG_BOX_MIN_X, c.box_min_x);
		write_reg(bcf_pkg::REG_BOX_MAX_X, c.box_max_x);
		write_reg(bcf_pkg::REG_BOX_MAX_Z, c.box_max_z);
		write_reg(bcf_pkg::REG_TARGET_DISTANCE, c.target_distance);
		write_reg(bcf_pkg::REG_FORWARD_GAIN, c.forward_gain);
		write_reg(bcf_pkg::REG_TURN_GAIN, c.turn_gain);
		cfg_valid = 1'b0;
		box = c;
	endtask

	initial begin
		bcf_pkg::bcf_cfg_t c;
		box = default_config();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Sender mostly busy, receiver mostly stalled
		tx_idle_pct = 19;
		rx_idle_pct = 85;

		// Reset box: a lone inside point, then each box edge
		send_point(mk_point(0, -300, 500, 1, 1, 1, 1));
		send_point(mk_point(0, -100, 0, 1, 0, 1, 0));
		send_point(mk_point(0, -500, 0, 1, 0, 0, 1));
		send_point(mk_point(-200, -300, 0, 1, 0, 1, 1));
		send_point(mk_point(200, -300, 0, 1, 0, 0, 0));
		send_point(mk_point(0, -300, 800, 1, 0, 1, 1));
		send_point(mk_point(199, -499, 799, 1, 0, 0, 1));
		send_point(mk_point(0, -300, 0, 0, 0, 1, 0));
		send_point(mk_point(-32768, -32768, -32768, 1, 0, 1, 1));
		send_point(mk_point(32767, 32767, 32767, 1, 0, 0, 0));
		send_point(mk_point(-199, -101, -32768, 1, 0, 1, 1));
		send_point(mk_point(0, -300, 100, 1, 1, 0, 1));
		// Invalid closing point, and a closing point far outside the box
		send_point(mk_point(0, -300, 100, 0, 1, 0, 0));
		send_point(mk_point(-32768, -32768, -32768, 1, 1, 1, 1));

		run_frames(200, 60);

		// Full-range box with extreme gains and distance
		apply_config(full_box_config());
		run_frames(200, 60);

		apply_config(random_config());
		run_frames(200, 60);

		// Sender mostly idle, receiver mostly ready
		tx_idle_pct = 85;
		rx_idle_pct = 19;

		// Inverted and empty box, zero gains
		c.box_min_y = 16'sd500;
		c.box_max_y = 16'sd100;
		c.box_min_x = 16'sd0;
		c.box_max_x = 16'sd1;
		c.box_max_z = 16'sh8000;
		c.target_distance = 16'sh7FFF;
		c.forward_gain = 16'd0;
		c.turn_gain = 16'd0;
		apply_config(c);
		run_frames(150, 60);

		apply_config(random_config());
		run_frames(200, 60);

		// No idling from here on
		tx_idle_pct = 0;
		rx_idle_pct = 0;

		c = default_config();
		c.target_distance = 16'sh7FFF;
		c.forward_gain = 16'hFFFF;
		c.turn_gain = 16'd1;
		apply_config(c);

		// Stall the results while short frames keep coming, so the input backs up
		rx_hold_req = 1'b1;
		run_frames(40, 4);
		run_frames(150, 60);

		// Full-range box again with the furthest distance
		c = full_box_config();
		c.target_distance = 16'sh7FFF;
		apply_config(c);
		run_frames(20, 8);

		s_axis_tvalid = 1'b0;
		wait_drained();

		$display("Sent %0d points in %0d frames, %0d of them over the point threshold.",
			follow_check.points, follow_check.frames, follow_check.targets);
		$display("Checked %0d result beats under default, full-range, random and empty boxes.",
			follow_check.results_checked);
		if (follow_check.fails == 0) begin
			$display("[box_centroid_follow_controller_top] OK");
		end else begin
			$display("[box_centroid_follow_controller_top] ERROR");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#40000000;
		$display("[box_centroid_follow_controller_top] ERROR");
		$finish;
	end

endmodule
